/* hw/rtl/assert_macros.svh */
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

/* hw/rtl/kf2_pkg.sv */
package kf2_pkg;
  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int NREGS = 6;
  localparam logic [2:0] REG_TRANS0 = 3'd0;
  localparam logic [2:0] REG_TRANS1 = 3'd1;
  localparam logic [2:0] REG_NOISE0 = 3'd2;
  localparam logic [2:0] REG_NOISE1 = 3'd3;
  localparam logic [2:0] REG_OBSERVE = 3'd4;
  localparam logic [2:0] REG_MEASVAR = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_DIV,
    ST_OUT
  } state_e;

  // Operand sources of the shared multiply-accumulate unit.
  typedef enum logic [4:0] {
    SRC_ZERO, SRC_A00, SRC_A01, SRC_A10, SRC_A11,
    SRC_H0, SRC_H1, SRC_X0, SRC_X1,
    SRC_P00, SRC_P01, SRC_P10, SRC_P11,
    SRC_T00, SRC_T01, SRC_T10, SRC_T11,
    SRC_K0, SRC_K1, SRC_ERR
  } src_e;

  // Addend applied before the final saturation of a sum.
  typedef enum logic [2:0] {
    ADD_NONE, ADD_Q00, ADD_Q01, ADD_Q10, ADD_Q11, ADD_R, ADD_X0, ADD_X1
  } add_e;
endpackage

/* hw/rtl/kalman_filter_two_state.sv */
// Two-state Kalman filter with one scalar measurement per item.
// The measurement channel (measurement_valid_i / measurement_ready_o) takes one
// item at a time; the result channel (result_valid_o / result_ready_i) carries
// both estimates with the degenerate and clipped flags.
// A single multiplier with a rounding accumulator is stepped through 46
// products, one per cycle, by a sequencer, and a restoring divider produces
// each of the two gains bit by bit. The next item can be accepted in the cycle
// after the result is taken. When the innovation variance is not positive the
// gains and the update are skipped.
// The block is not ready while an item is in work or while its result waits;
// a stalled receiver simply holds the result until it is taken.
// The user writes configuration over the APB port only while idle; the block does not enforce it.
// Reset sets the state to zero, the covariance to identity and the registers
// to their documented defaults; no clearing pass is needed.
module kalman_filter_two_state
  import kf2_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        measurement_valid_i,
  output logic        measurement_ready_o,
  input  logic signed [31:0] measurement_i,
  output logic        result_valid_o,
  input  logic        result_ready_i,
  output logic signed [31:0] estimate_first_o,
  output logic signed [31:0] estimate_second_o,
  output logic        degenerate_o,
  output logic        clipped_o
);
  localparam int W = WORD_BITS;
  localparam int F = FRAC_BITS;
  localparam int PW = 2 * W;
  localparam int AW = PW + 3;
  localparam int NB = W + F + 1;
  localparam int NBW = $clog2(NB + 2);
  localparam logic signed [AW-1:0] WMAX_A = AW'((64'sd1 <<< (W - 1)) - 1);
  localparam logic signed [AW-1:0] WMIN_A = -AW'(64'sd1 <<< (W - 1));
  localparam logic signed [W-1:0] ONE_W = (F >= W - 1) ? W'((64'sd1 <<< (W - 1)) - 1)
                                                      : W'(64'sd1 <<< F);

  // Configuration registers.
  logic [63:0] reg_q [NREGS];
  logic [63:0] reg_d [NREGS];
  logic [2:0]  cfg_idx;
  logic        cfg_wr;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[5:3];
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    prdata = 64'd0;
    if (32'(cfg_idx) < NREGS) begin
      prdata = reg_q[cfg_idx];
    end
  end

  always_comb begin
    for (int i = 0; i < NREGS; i++) begin
      reg_d[i] = reg_q[i];
    end
    if (cfg_wr && (32'(cfg_idx) < NREGS)) begin
      if (cfg_idx == REG_MEASVAR) begin
        reg_d[cfg_idx] = {33'd0, pwdata[30:0]};
      end else begin
        reg_d[cfg_idx] = pwdata;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reg_q[REG_TRANS0]  <= 64'd65536;
      reg_q[REG_TRANS1]  <= 64'd1 << 48;
      reg_q[REG_NOISE0]  <= 64'd0;
      reg_q[REG_NOISE1]  <= 64'd0;
      reg_q[REG_OBSERVE] <= 64'd65536;
      reg_q[REG_MEASVAR] <= 64'd0;
    end else begin
      for (int i = 0; i < NREGS; i++) begin
        reg_q[i] <= reg_d[i];
      end
    end
  end

  function automatic logic signed [W-1:0] half_entry(input logic [63:0] r, input logic hi);
    logic [31:0] h;
    h = hi ? r[63:32] : r[31:0];
    return h[W-1:0];
  endfunction

  // Filter state and working values.
  logic signed [W-1:0] x_q [2];
  logic signed [W-1:0] p_q [4];
  logic signed [W-1:0] t_q [4];
  logic signed [W-1:0] xp_q [2];
  logic signed [W-1:0] k_q [2];
  logic signed [W-1:0] ph_q [2];
  logic signed [W-1:0] hp_q [2];
  logic signed [W-1:0] s_q, err_q, z_q, hx_q;
  logic                degen_q, clip_q;

  state_e state_q, state_d;
  logic [5:0] step_q;
  logic       half_q;
  logic signed [AW-1:0] acc_q;

  // Divider.
  logic [NB-1:0]  dquo_q;
  logic [W:0]     drem_q;
  logic [NB-1:0]  dnum_q;
  logic [NBW-1:0] dcnt_q;
  logic           dsel_q;
  logic           dneg_q;

  // Step table: up to two operand pairs per step, the addend and the destination.
  src_e sa0, sb0, sa1, sb1;
  add_e addsel;
  logic [4:0] dest;
  logic       subtract;

  always_comb begin
    sa0 = SRC_ZERO; sb0 = SRC_ZERO; sa1 = SRC_ZERO; sb1 = SRC_ZERO;
    addsel = ADD_NONE; dest = 5'd0; subtract = 1'b0;
    case (step_q)
      6'd0:  begin sa0=SRC_A00; sb0=SRC_X0; sa1=SRC_A01; sb1=SRC_X1; dest=5'd0; end
      6'd1:  begin sa0=SRC_A10; sb0=SRC_X0; sa1=SRC_A11; sb1=SRC_X1; dest=5'd1; end
      6'd2:  begin sa0=SRC_A00; sb0=SRC_P00; sa1=SRC_A01; sb1=SRC_P10; dest=5'd2; end
      6'd3:  begin sa0=SRC_A00; sb0=SRC_P01; sa1=SRC_A01; sb1=SRC_P11; dest=5'd3; end
      6'd4:  begin sa0=SRC_A10; sb0=SRC_P00; sa1=SRC_A11; sb1=SRC_P10; dest=5'd4; end
      6'd5:  begin sa0=SRC_A10; sb0=SRC_P01; sa1=SRC_A11; sb1=SRC_P11; dest=5'd5; end
      6'd6:  begin sa0=SRC_T00; sb0=SRC_A00; sa1=SRC_T01; sb1=SRC_A01; addsel=ADD_Q00;
                   dest=5'd6; end
      6'd7:  begin sa0=SRC_T00; sb0=SRC_A10; sa1=SRC_T01; sb1=SRC_A11; addsel=ADD_Q01;
                   dest=5'd7; end
      6'd8:  begin sa0=SRC_T10; sb0=SRC_A00; sa1=SRC_T11; sb1=SRC_A01; addsel=ADD_Q10;
                   dest=5'd8; end
      6'd9:  begin sa0=SRC_T10; sb0=SRC_A10; sa1=SRC_T11; sb1=SRC_A11; addsel=ADD_Q11;
                   dest=5'd9; end
      6'd10: begin sa0=SRC_P00; sb0=SRC_H0; sa1=SRC_P01; sb1=SRC_H1; dest=5'd10; end
      6'd11: begin sa0=SRC_P10; sb0=SRC_H0; sa1=SRC_P11; sb1=SRC_H1; dest=5'd11; end
      6'd12: begin sa0=SRC_H0; sb0=SRC_P00; sa1=SRC_H1; sb1=SRC_P10; dest=5'd12; end
      6'd13: begin sa0=SRC_H0; sb0=SRC_P01; sa1=SRC_H1; sb1=SRC_P11; dest=5'd13; end
      6'd14: begin sa0=SRC_T00; sb0=SRC_H0; sa1=SRC_T01; sb1=SRC_H1; addsel=ADD_R;
                   dest=5'd14; end
      6'd15: begin sa0=SRC_H0; sb0=SRC_X0; sa1=SRC_H1; sb1=SRC_X1; dest=5'd15; end
      6'd16: begin sa0=SRC_K0; sb0=SRC_ERR; addsel=ADD_X0; dest=5'd16; end
      6'd17: begin sa0=SRC_K1; sb0=SRC_ERR; addsel=ADD_X1; dest=5'd17; end
      6'd18: begin sa0=SRC_K0; sb0=SRC_H0; subtract=1'b1; dest=5'd18; end
      6'd19: begin sa0=SRC_K0; sb0=SRC_H1; subtract=1'b1; dest=5'd19; end
      6'd20: begin sa0=SRC_K1; sb0=SRC_H0; subtract=1'b1; dest=5'd20; end
      6'd21: begin sa0=SRC_K1; sb0=SRC_H1; subtract=1'b1; dest=5'd21; end
      6'd22: begin sa0=SRC_T00; sb0=SRC_P00; sa1=SRC_T01; sb1=SRC_P10; dest=5'd22; end
      6'd23: begin sa0=SRC_T00; sb0=SRC_P01; sa1=SRC_T01; sb1=SRC_P11; dest=5'd23; end
      6'd24: begin sa0=SRC_T10; sb0=SRC_P00; sa1=SRC_T11; sb1=SRC_P10; dest=5'd24; end
      6'd25: begin sa0=SRC_T10; sb0=SRC_P01; sa1=SRC_T11; sb1=SRC_P11; dest=5'd25; end
      default: ;
    endcase
  end

  function automatic logic signed [W-1:0] pick(input src_e s,
      input logic signed [W-1:0] a00, input logic signed [W-1:0] a01,
      input logic signed [W-1:0] a10, input logic signed [W-1:0] a11,
      input logic signed [W-1:0] h0, input logic signed [W-1:0] h1,
      input logic signed [W-1:0] x0, input logic signed [W-1:0] x1,
      input logic signed [W-1:0] p00, input logic signed [W-1:0] p01,
      input logic signed [W-1:0] p10, input logic signed [W-1:0] p11,
      input logic signed [W-1:0] t00, input logic signed [W-1:0] t01,
      input logic signed [W-1:0] t10, input logic signed [W-1:0] t11,
      input logic signed [W-1:0] k0, input logic signed [W-1:0] k1,
      input logic signed [W-1:0] e);
    logic signed [W-1:0] v;
    v = '0;
    case (s)
      SRC_A00: v = a00;
      SRC_A01: v = a01;
      SRC_A10: v = a10;
      SRC_A11: v = a11;
      SRC_H0:  v = h0;
      SRC_H1:  v = h1;
      SRC_X0:  v = x0;
      SRC_X1:  v = x1;
      SRC_P00: v = p00;
      SRC_P01: v = p01;
      SRC_P10: v = p10;
      SRC_P11: v = p11;
      SRC_T00: v = t00;
      SRC_T01: v = t01;
      SRC_T10: v = t10;
      SRC_T11: v = t11;
      SRC_K0:  v = k0;
      SRC_K1:  v = k1;
      SRC_ERR: v = e;
      default: v = '0;
    endcase
    return v;
  endfunction

  logic signed [W-1:0] a00, a01, a10, a11, h0, h1;
  assign a00 = half_entry(reg_q[REG_TRANS0], 1'b0);
  assign a01 = half_entry(reg_q[REG_TRANS0], 1'b1);
  assign a10 = half_entry(reg_q[REG_TRANS1], 1'b0);
  assign a11 = half_entry(reg_q[REG_TRANS1], 1'b1);
  assign h0  = half_entry(reg_q[REG_OBSERVE], 1'b0);
  assign h1  = half_entry(reg_q[REG_OBSERVE], 1'b1);

  // Operands of the covariance and state reads depend on the phase:
  // prediction uses the stored P and x, later steps the predicted ones.
  logic signed [W-1:0] px00, px01, px10, px11, xx0, xx1;
  logic pred_phase;
  assign pred_phase = (step_q < 6'd6);
  assign px00 = pred_phase ? p_q[0] : t_q[0];
  assign px01 = pred_phase ? p_q[1] : t_q[1];
  assign px10 = pred_phase ? p_q[2] : t_q[2];
  assign px11 = pred_phase ? p_q[3] : t_q[3];
  assign xx0  = (step_q < 6'd2) ? x_q[0] : xp_q[0];
  assign xx1  = (step_q < 6'd2) ? x_q[1] : xp_q[1];

  // Working temporaries: AP during prediction, P_pred for gain and update,
  // and I-KH for the final product; pp_q holds P_pred while t_q holds I-KH.
  logic signed [W-1:0] pp_q [4];
  logic signed [W-1:0] tt00, tt01, tt10, tt11;
  logic use_pp;
  assign use_pp = (step_q >= 6'd10);
  assign tt00 = (step_q >= 6'd22) ? t_q[0] : (step_q == 6'd14 ? hp_q[0] : t_q[0]);
  assign tt01 = (step_q >= 6'd22) ? t_q[1] : (step_q == 6'd14 ? hp_q[1] : t_q[1]);
  assign tt10 = t_q[2];
  assign tt11 = t_q[3];

  logic signed [W-1:0] opa, opb;
  logic signed [PW-1:0] prod;
  logic signed [AW-1:0] rnd;
  src_e sa, sb;

  assign sa = half_q ? sa1 : sa0;
  assign sb = half_q ? sb1 : sb0;
  assign opa = pick(sa, a00, a01, a10, a11, h0, h1, xx0, xx1,
                    use_pp ? pp_q[0] : px00, use_pp ? pp_q[1] : px01,
                    use_pp ? pp_q[2] : px10, use_pp ? pp_q[3] : px11,
                    tt00, tt01, tt10, tt11, k_q[0], k_q[1], err_q);
  assign opb = pick(sb, a00, a01, a10, a11, h0, h1, xx0, xx1,
                    use_pp ? pp_q[0] : px00, use_pp ? pp_q[1] : px01,
                    use_pp ? pp_q[2] : px10, use_pp ? pp_q[3] : px11,
                    tt00, tt01, tt10, tt11, k_q[0], k_q[1], err_q);
  assign prod = opa * opb;
  assign rnd  = AW'((prod + (PW'(1) <<< (F - 1))) >>> F);

  logic signed [AW-1:0] addv, total;
  logic signed [W-1:0]  total_sat;
  logic                 total_clip;
  always_comb begin
    case (addsel)
      ADD_Q00: addv = AW'(half_entry(reg_q[REG_NOISE0], 1'b0));
      ADD_Q01: addv = AW'(half_entry(reg_q[REG_NOISE0], 1'b1));
      ADD_Q10: addv = AW'(half_entry(reg_q[REG_NOISE1], 1'b0));
      ADD_Q11: addv = AW'(half_entry(reg_q[REG_NOISE1], 1'b1));
      ADD_R:   addv = AW'(s_q);
      ADD_X0:  addv = AW'(xp_q[0]);
      ADD_X1:  addv = AW'(xp_q[1]);
      default: addv = '0;
    endcase
    if (subtract) begin
      total = ((dest == 5'd18 || dest == 5'd21) ? AW'(ONE_W) : '0) - rnd;
    end else begin
      total = acc_q + rnd + addv;
    end
    if (total > WMAX_A) begin
      total_sat = WMAX_A[W-1:0]; total_clip = 1'b1;
    end else if (total < WMIN_A) begin
      total_sat = WMIN_A[W-1:0]; total_clip = 1'b1;
    end else begin
      total_sat = total[W-1:0]; total_clip = 1'b0;
    end
  end

  // The step finishes after its second product, or after one for single
  // products.
  logic single;
  assign single = (sa1 == SRC_ZERO);
  logic step_done;
  assign step_done = half_q || single;

  // Innovation and saturated inputs.
  logic signed [AW-1:0] err_full;
  assign err_full = AW'(z_q) - AW'(hx_q);

  logic signed [AW-1:0] z_full;
  logic signed [W-1:0]  z_sat;
  logic                 z_clip;
  assign z_full = AW'(measurement_i);
  always_comb begin
    if (z_full > WMAX_A) begin
      z_sat = WMAX_A[W-1:0]; z_clip = 1'b1;
    end else if (z_full < WMIN_A) begin
      z_sat = WMIN_A[W-1:0]; z_clip = 1'b1;
    end else begin
      z_sat = z_full[W-1:0]; z_clip = 1'b0;
    end
  end

  // Divider datapath: magnitude of the numerator shifted left by F over S.
  logic [W:0] drem_sh;
  logic       dge;
  assign drem_sh = {drem_q[W-1:0], dnum_q[NB-1]};
  assign dge = (drem_sh >= {1'b0, s_q});

  logic [NB:0]  qround;
  logic signed [AW-1:0] kval;
  logic [W:0] twice_rem;
  assign twice_rem = {drem_q[W-1:0], 1'b0};
  assign qround = {1'b0, dquo_q} + ((twice_rem >= {1'b0, s_q}) ? 1'b1 : 1'b0);
  assign kval = dneg_q ? -AW'(qround) : AW'(qround);

  logic signed [W-1:0] ph_mag_src;
  assign ph_mag_src = dsel_q ? ph_q[1] : ph_q[0];
  logic [W-1:0] ph_abs;
  assign ph_abs = ph_mag_src[W-1] ? W'(-ph_mag_src) : W'(ph_mag_src);

  assign measurement_ready_o = (state_q == ST_IDLE);
  assign result_valid_o      = (state_q == ST_OUT);
  assign estimate_first_o    = 32'(x_q[0]);
  assign estimate_second_o   = 32'(x_q[1]);
  assign degenerate_o        = degen_q;
  assign clipped_o           = clip_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (measurement_valid_i) state_d = ST_LOAD;
      ST_LOAD: state_d = ST_MUL;
      ST_MUL: begin
        if (step_done && step_q == 6'd14 && total_sat <= 0) state_d = ST_OUT;
        else if (step_done && step_q == 6'd15) state_d = ST_DIV;
        else if (step_done && step_q == 6'd25) state_d = ST_OUT;
      end
      ST_DIV: if (dcnt_q == NBW'(NB + 1) && dsel_q) state_d = ST_MUL;
      ST_OUT: if (result_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      half_q  <= 1'b0;
      dcnt_q  <= '0;
      dsel_q  <= 1'b0;
      x_q[0]  <= '0;
      x_q[1]  <= '0;
      p_q[0]  <= ONE_W;
      p_q[1]  <= '0;
      p_q[2]  <= '0;
      p_q[3]  <= ONE_W;
      degen_q <= 1'b0;
      clip_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_IDLE: begin
          if (measurement_valid_i) begin
            z_q     <= z_sat;
            clip_q  <= z_clip;
            degen_q <= 1'b0;
            step_q  <= '0;
            half_q  <= 1'b0;
            acc_q   <= '0;
            s_q     <= '0;
          end
        end
        ST_LOAD: begin
          // Saturate R into the word range.
          if (reg_q[REG_MEASVAR][30:0] > 31'(WMAX_A)) begin
            s_q <= WMAX_A[W-1:0];
            clip_q <= 1'b1;
          end else begin
            s_q <= reg_q[REG_MEASVAR][W-1:0];
          end
        end
        ST_MUL: begin
          if (!step_done) begin
            half_q <= 1'b1;
            acc_q  <= acc_q + rnd;
          end else begin
            half_q <= 1'b0;
            acc_q  <= '0;
            step_q <= step_q + 6'd1;
            if (total_clip) clip_q <= 1'b1;
            case (dest)
              5'd0: xp_q[0] <= total_sat;
              5'd1: xp_q[1] <= total_sat;
              5'd2, 5'd3, 5'd4, 5'd5: t_q[dest[1:0] - 2'd2] <= total_sat;
              5'd6, 5'd7, 5'd8, 5'd9: pp_q[dest[1:0] - 2'd2] <= total_sat;
              5'd10: ph_q[0] <= total_sat;
              5'd11: ph_q[1] <= total_sat;
              5'd12: hp_q[0] <= total_sat;
              5'd13: hp_q[1] <= total_sat;
              5'd14: begin
                s_q <= total_sat;
                if (total_sat <= 0) begin
                  degen_q <= 1'b1;
                  x_q[0] <= xp_q[0];
                  x_q[1] <= xp_q[1];
                  for (int i = 0; i < 4; i++) p_q[i] <= pp_q[i];
                end
              end
              5'd15: begin
                hx_q   <= total_sat;
                dcnt_q <= '0;
                dsel_q <= 1'b0;
                dquo_q <= '0;
                drem_q <= '0;
              end
              5'd16: x_q[0] <= total_sat;
              5'd17: x_q[1] <= total_sat;
              5'd18, 5'd19, 5'd20, 5'd21: t_q[dest[1:0] - 2'd2] <= total_sat;
              5'd22, 5'd23, 5'd24, 5'd25: p_q[dest[1:0] - 2'd2] <= total_sat;
              default: ;
            endcase
          end
        end
        ST_DIV: begin
          if (dcnt_q == '0) begin
            dnum_q <= {1'b0, ph_abs, F'(0)};
            dneg_q <= ph_mag_src[W-1];
            dcnt_q <= dcnt_q + NBW'(1);
            if (!dsel_q) begin
              // The innovation is formed once, ahead of the first gain.
              if (err_full > WMAX_A) begin
                err_q <= WMAX_A[W-1:0]; clip_q <= 1'b1;
              end else if (err_full < WMIN_A) begin
                err_q <= WMIN_A[W-1:0]; clip_q <= 1'b1;
              end else begin
                err_q <= err_full[W-1:0];
              end
            end
          end else if (dcnt_q <= NBW'(NB)) begin
            dnum_q <= {dnum_q[NB-2:0], 1'b0};
            drem_q <= dge ? (drem_sh - {1'b0, s_q}) : drem_sh;
            dquo_q <= {dquo_q[NB-2:0], dge};
            dcnt_q <= dcnt_q + NBW'(1);
          end else begin
            if (kval > WMAX_A) begin
              k_q[dsel_q] <= WMAX_A[W-1:0]; clip_q <= 1'b1;
            end else if (kval < WMIN_A) begin
              k_q[dsel_q] <= WMIN_A[W-1:0]; clip_q <= 1'b1;
            end else begin
              k_q[dsel_q] <= kval[W-1:0];
            end
            dsel_q <= 1'b1;
            dcnt_q <= '0;
            dquo_q <= '0;
            drem_q <= '0;
            dneg_q <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

/* hw/rtl/kf2_checker.sv */
`include "assert_macros.svh"
module kf2_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic measurement_valid_i,
  input logic measurement_ready_o,
  input logic result_valid_o,
  input logic result_ready_i,
  input logic [31:0] estimate_first_o,
  input logic degenerate_o
);
  `ASSERT_IMPL(no_accept_while_result, clk_i, rst_ni, result_valid_o, !measurement_ready_o, "input taken while a result waits")
  `ASSERT_NEXT(no_result_after_accept, clk_i, rst_ni, measurement_valid_i && measurement_ready_o, !result_valid_o, "result appeared straight after acceptance")
  `ASSERT_NEXT(result_holds, clk_i, rst_ni, result_valid_o && !result_ready_i, result_valid_o && $stable(estimate_first_o) && $stable(degenerate_o), "stalled result changed")
endmodule

bind kalman_filter_two_state kf2_checker u_kf2_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .measurement_valid_i(measurement_valid_i),
  .measurement_ready_o(measurement_ready_o),
  .result_valid_o(result_valid_o),
  .result_ready_i(result_ready_i),
  .estimate_first_o(estimate_first_o),
  .degenerate_o(degenerate_o)
);
